@@ hw/rtl/bounded_array_list_assert.svh @@
// Assertion macros for the bounded array list
`ifndef BOUNDED_ARRAY_LIST_ASSERT_SVH
`define BOUNDED_ARRAY_LIST_ASSERT_SVH

`ifndef SYNTH

// Check under reset gating
`define BAL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every edge, reset included
`define BAL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BAL_ASSERT(lbl, clk, rst_n, prop, msg)

`define BAL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/bal_pkg.sv @@
package bal_pkg;

  localparam int unsigned BalCapacity = 16;
  localparam int unsigned BalDataW    = 32;
  localparam int unsigned BalPosW     = 4;
  localparam int unsigned BalCntW     = 5;

  typedef enum logic [1:0] {
    BalOpAppend = 2'd0,
    BalOpRemove = 2'd1,
    BalOpFind   = 2'd2
  } bal_op_e;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [BalDataW-1:0] value;
  } bal_in_t;

  typedef struct packed {
    logic                       ok;
    logic [BalPosW-1:0]         position;
    logic [BalCntW-1:0]         count;
    logic                       is_empty;
    logic signed [BalDataW-1:0] largest;
  } bal_out_t;

endpackage

@@ hw/rtl/bal_ram.sv @@
module bal_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bounded_array_list.sv @@
// Bounded array list: up to Capacity signed 32-bit values in insertion order.
// Input channel in_valid_i/in_ready_o carries an op (append, remove first
// match, find first match) and a value; output channel out_valid_o/out_ready_i
// returns one result per item: ok, matched position, count, empty flag and
// the largest stored value (0 when empty).
// Append writes its entry at once and, like unused ops, goes straight to the
// result. Find and remove read the stored entries in a search pass; a remove
// that matches then shifts the entries after the match down by one index.
// Both passes are paced by the single read port of the entry RAM, giving
// one entry per cycle to the search and to the shift.
// The largest value is kept in a register, updated on append and taken from
// the search pass on remove, so no second scan is needed.
// One item is in work at a time; in_ready_o is high only when the sequencer
// is idle. A finished result sits in the output register while the next item
// is taken; if the receiver stalls, the following result waits in the
// sequencer until the output register frees.
// Reset empties the list at once: no clearing pass, the RAM contents are
// only read below the fill count.
module bounded_array_list #(
  parameter int unsigned Capacity = bal_pkg::BalCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bal_pkg::bal_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bal_pkg::bal_out_t out_o
);

  import bal_pkg::*;

`include "bounded_array_list_assert.svh"

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StScan  = 4'b0010,
    StShift = 4'b0100,
    StResp  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]                 op_q, op_d;
  logic signed [BalDataW-1:0] val_q, val_d;
  logic [CntW-1:0]            fill_q, fill_d;
  logic signed [BalDataW-1:0] largest_q, largest_d;
  logic [CntW-1:0]            rd_idx_q, rd_idx_d;
  logic                       rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]            tag_q, tag_d;
  logic                       found_q, found_d;
  logic [IdxW-1:0]            match_q, match_d;
  logic signed [BalDataW-1:0] mx_q, mx_d;
  logic                       mx_vld_q, mx_vld_d;
  logic                       ok_q, ok_d;
  logic [IdxW-1:0]            pos_q, pos_d;
  bal_out_t                   out_q, out_d;
  logic                       out_valid_q, out_valid_d;

  logic                       ram_we;
  logic [IdxW-1:0]            ram_waddr;
  logic [BalDataW-1:0]        ram_wdata;
  logic [BalDataW-1:0]        ram_rdata;
  logic signed [BalDataW-1:0] rdata_s;
  logic                       issue;
  logic                       in_xfer;

  bal_ram #(
    .Width (BalDataW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rdata_s    = $signed(ram_rdata);
  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign issue      = (rd_idx_q < fill_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    fill_d      = fill_q;
    largest_d   = largest_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    tag_d       = tag_q;
    found_d     = found_q;
    match_d     = match_q;
    mx_d        = mx_q;
    mx_vld_d    = mx_vld_q;
    ok_d        = ok_q;
    pos_d       = pos_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = fill_q[IdxW-1:0];
    ram_wdata   = in_i.value;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          op_d     = in_i.op;
          val_d    = in_i.value;
          ok_d     = 1'b0;
          pos_d    = '0;
          rd_idx_d = '0;
          found_d  = 1'b0;
          mx_vld_d = 1'b0;
          case (in_i.op)
            BalOpAppend: begin
              state_d = StResp;
              if (fill_q < CntW'(Capacity)) begin
                ram_we = 1'b1;
                fill_d = fill_q + CntW'(1);
                ok_d   = 1'b1;
                if (fill_q == '0 || in_i.value > largest_q) begin
                  largest_d = in_i.value;
                end
              end
            end
            BalOpRemove, BalOpFind: begin
              state_d = StScan;
            end
            default: begin
              state_d = StResp;
            end
          endcase
        end
      end

      StScan: begin
        rd_vld_d = issue;
        tag_d    = rd_idx_q[IdxW-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (!found_q && rdata_s == val_q) begin
            found_d = 1'b1;
            match_d = tag_q;
          end else begin
            if (!mx_vld_q || rdata_s > mx_q) begin
              mx_d = rdata_s;
            end
            mx_vld_d = 1'b1;
          end
        end else if (!issue) begin
          ok_d  = found_q;
          pos_d = found_q ? match_q : '0;
          if (op_q == BalOpRemove && found_q) begin
            largest_d = mx_vld_q ? mx_q : '0;
            rd_idx_d  = CntW'(match_q) + CntW'(1);
            state_d   = StShift;
          end else begin
            state_d = StResp;
          end
        end
      end

      StShift: begin
        rd_vld_d = issue;
        tag_d    = rd_idx_q[IdxW-1:0];
        if (issue) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = tag_q - IdxW'(1);
          ram_wdata = ram_rdata;
        end else if (!issue) begin
          fill_d  = fill_q - CntW'(1);
          state_d = StResp;
        end
      end

      StResp: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.ok       = ok_q;
          out_d.position = BalPosW'(pos_q);
          out_d.count    = BalCntW'(fill_q);
          out_d.is_empty = (fill_q == '0);
          out_d.largest  = (fill_q == '0) ? '0 : largest_q;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      mx_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      mx_vld_q    <= mx_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    largest_q <= largest_d;
    tag_q     <= tag_d;
    match_q   <= match_d;
    mx_q      <= mx_d;
    ok_q      <= ok_d;
    pos_q     <= pos_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `BAL_ASSERT_ALWAYS(a_fill_bound, clk_i, fill_q <= CntW'(Capacity), "fill count beyond capacity")
  `BAL_ASSERT(a_shift_found, clk_i, rst_ni,
    (state_q == StShift) |-> found_q, "shift without match")
  `BAL_ASSERT(a_shift_waddr, clk_i, rst_ni,
    (state_q == StShift && rd_vld_q) |-> (tag_q != '0), "shift write below index zero")
  `BAL_ASSERT(a_idle_no_read, clk_i, rst_ni,
    in_ready_o |-> !rd_vld_q, "read in flight while idle")
  `BAL_ASSERT(a_append_grows, clk_i, rst_ni,
    (in_xfer && in_i.op == BalOpAppend && fill_q < CntW'(Capacity))
      |=> (fill_q == $past(fill_q) + CntW'(1)), "append did not grow list")

endmodule
